// ===== rtl/dgcp_pkg.sv =====
// Package for the dual-grid contour plotter.
// Holds cursor widths, error codes, register indexes and the structs shared
// by the step, drain and top-level modules. Depends on nothing.
`default_nettype none

package dgcp_pkg;

  localparam int CUR_W   = 13;
  localparam int PT_W    = 11;
  localparam int PIX_W   = 12;
  localparam int ADDR_W  = 23;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 2;
  localparam int SLOTS   = 3;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_ADJ   = 2'd2
  } err_t;

  localparam logic [IDX_W-1:0] CFG_ROWS   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_COLS   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_BORDER = 2'd2;

  typedef struct packed {
    logic [CUR_W-1:0] rows;
    logic [CUR_W-1:0] cols;
    logic             border;
  } cfg_t;

  typedef struct packed {
    logic [PT_W-1:0] x;
    logic [PT_W-1:0] y;
    logic            first;
    logic            last;
    logic            closed;
  } item_t;

  typedef struct packed {
    logic [CUR_W-1:0] row;
    logic [CUR_W-1:0] col;
    err_t             err;
  } pix_t;

  typedef struct packed {
    pix_t [SLOTS-1:0] ent;
    logic [1:0]       cnt;
  } set_t;

endpackage

`default_nettype wire

// ===== rtl/dgcp_in_if.sv =====
// Input channel of the dual-grid contour plotter: one curve point per transfer.
// Depends on nothing.
`default_nettype none

interface dgcp_in_if;
  logic        valid;
  logic        ready;
  logic [10:0] point_x;
  logic [10:0] point_y;
  logic        line_start;
  logic        last_point;
  logic        line_closed;

  modport source (output valid, point_x, point_y, line_start, last_point, line_closed,
                  input ready);
  modport sink   (input valid, point_x, point_y, line_start, last_point, line_closed,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/dgcp_out_if.sv =====
// Result channel of the dual-grid contour plotter: one pixel write or error per transfer.
// Depends on nothing.
`default_nettype none

interface dgcp_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_row;
  logic [11:0] pixel_col;
  logic [22:0] pixel_address;
  logic [1:0]  error_code;
  logic        last_result;

  modport source (output valid, pixel_row, pixel_col, pixel_address, error_code, last_result,
                  input ready);
  modport sink   (input valid, pixel_row, pixel_col, pixel_address, error_code, last_result,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/dual_grid_contour_plotter.sv =====
// Dual-grid contour plotter top level: configuration registers, point tracking
// and result drain. Depends on dgcp_pkg, dgcp_in_if, dgcp_out_if, dgcp_step, dgcp_drain.
//
// Usage:
//   in_ch carries one point of a 4-connected level line per transfer, flagged
//   line_start, last_point and line_closed. out_ch carries pixel writes into a
//   raster of about twice the size, or an error result with zero pixel fields.
//   Each point gives zero to three results; last_result marks its final one.
//   cfg_we/cfg_index/cfg_data write grid_rows (0), grid_cols (1) and
//   border_mode (2); sizes above MAX_DIM saturate. Write only while idle.
//   A point passes the input register, the result buffer and the output
//   register. One result per cycle while out_ch is ready; a point holds the
//   result buffer until its last result is taken, and the drain forms every
//   pixel address with a single multiplier as the entry enters the output register.
//   While out_ch is stalled the output register holds its result, one more
//   point set waits in the buffer and one more point in the input register.
//   Reset (rst_n low, synchronous) empties all stages, clears the line state
//   to point (0,0) and sets grid sizes to MAX_DIM and border_mode to 0.
`default_nettype none

module dual_grid_contour_plotter #(
  parameter int MAX_DIM = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [dgcp_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [dgcp_pkg::CFG_W-1:0]      cfg_data,
  dgcp_in_if.sink                              in_ch,
  dgcp_out_if.source                           out_ch
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  logic [DIM_W-1:0] rows_r, cols_r, dim_val;
  logic             border_r;
  dgcp_pkg::cfg_t   cfg;
  dgcp_pkg::set_t   set;
  logic             set_valid, set_ready;

  assign dim_val = (32'(cfg_data) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= DIM_W'(MAX_DIM);
      cols_r   <= DIM_W'(MAX_DIM);
      border_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dgcp_pkg::CFG_ROWS:   rows_r   <= dim_val;
        dgcp_pkg::CFG_COLS:   cols_r   <= dim_val;
        dgcp_pkg::CFG_BORDER: border_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = '{rows: dgcp_pkg::CUR_W'(rows_r), cols: dgcp_pkg::CUR_W'(cols_r),
                 border: border_r};

  dgcp_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .set       (set),
    .set_valid (set_valid),
    .set_ready (set_ready)
  );

  dgcp_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .set       (set),
    .set_valid (set_valid),
    .set_ready (set_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/dgcp_step.sv =====
// Input register and line tracking of the contour plotter: turns one point into
// a packed set of up to three pixel or error entries. Depends on dgcp_pkg, dgcp_in_if.
`default_nettype none

module dgcp_step (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire dgcp_pkg::cfg_t cfg,
  dgcp_in_if.sink            in_ch,
  output dgcp_pkg::set_t     set,
  output logic               set_valid,
  input  wire logic          set_ready
);

  localparam int CW = dgcp_pkg::CUR_W;
  localparam int PW = dgcp_pkg::PT_W;

  dgcp_pkg::item_t  s1_r;
  logic             s1_valid_r;
  logic [PW-1:0]    prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [PW-1:0]    start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic [CW-1:0]    cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic             failed_r, failed_nxt;
  logic             fire;

  dgcp_pkg::pix_t [dgcp_pkg::SLOTS-1:0] cand;
  logic [dgcp_pkg::SLOTS-1:0]           keep;

  logic             in_grid;
  logic [PW:0]      dy, dx, cdy, cdx;
  logic [CW-1:0]    sdy, sdx, csdy, csdx;
  logic [CW-1:0]    r0, c0, r1, c1, r2, c2, r3, c3;
  logic [CW-1:0]    bnl, bnc;
  logic             adj, cadj;
  logic [1:0]       n;

  function automatic logic adjacent(input logic [PW:0] d_l, input logic [PW:0] d_c);
    logic l_one, c_one, l_zero, c_zero;
    l_one  = (d_l == (PW+1)'(1)) || (d_l == '1);
    c_one  = (d_c == (PW+1)'(1)) || (d_c == '1);
    l_zero = (d_l == '0);
    c_zero = (d_c == '0);
    return (l_one && c_zero) || (l_zero && c_one);
  endfunction

  function automatic logic skipped(input logic [CW-1:0] r, input logic [CW-1:0] c,
                                   input logic border, input logic [CW-1:0] fl,
                                   input logic [CW-1:0] fc);
    return !border && ((r == '1) || (c == '1) || (r == fl) || (c == fc));
  endfunction

  assign fire        = s1_valid_r && set_ready;
  assign set_valid   = s1_valid_r;
  assign in_ch.ready = !s1_valid_r || set_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_r <= '{x: in_ch.point_x, y: in_ch.point_y, first: in_ch.line_start,
                last: in_ch.last_point, closed: in_ch.line_closed};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      start_x_r <= '0;
      start_y_r <= '0;
      cur_row_r <= '0;
      cur_col_r <= '0;
      failed_r  <= 1'b0;
    end else if (fire) begin
      prev_x_r  <= prev_x_nxt;
      prev_y_r  <= prev_y_nxt;
      start_x_r <= start_x_nxt;
      start_y_r <= start_y_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      failed_r  <= failed_nxt;
    end
  end

  always_comb begin
    prev_x_nxt  = prev_x_r;
    prev_y_nxt  = prev_y_r;
    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    failed_nxt  = failed_r;
    cand        = '0;
    keep        = '0;

    bnl     = CW'({cfg.rows, 1'b0}) - CW'(1);
    bnc     = CW'({cfg.cols, 1'b0}) - CW'(1);
    in_grid = (CW'(s1_r.x) <= cfg.cols) && (CW'(s1_r.y) <= cfg.rows);

    if (cfg.border) begin
      r0 = CW'({s1_r.y, 1'b0});
      c0 = CW'({s1_r.x, 1'b0});
    end else begin
      r0 = CW'({s1_r.y, 1'b0}) - CW'(1);
      c0 = CW'({s1_r.x, 1'b0}) - CW'(1);
    end

    dy   = {1'b0, s1_r.y} - {1'b0, prev_y_r};
    dx   = {1'b0, s1_r.x} - {1'b0, prev_x_r};
    sdy  = {dy[PW], dy};
    sdx  = {dx[PW], dx};
    adj  = adjacent(dy, dx);
    r1   = cur_row_r + sdy;
    c1   = cur_col_r + sdx;
    r2   = r1 + sdy;
    c2   = c1 + sdx;
    cdy  = {1'b0, start_y_r} - {1'b0, s1_r.y};
    cdx  = {1'b0, start_x_r} - {1'b0, s1_r.x};
    csdy = {cdy[PW], cdy};
    csdx = {cdx[PW], cdx};
    cadj = adjacent(cdy, cdx);
    r3   = r2 + csdy;
    c3   = c2 + csdx;

    if (s1_r.first) begin
      failed_nxt = 1'b0;
      if (!in_grid) begin
        cand[0]    = '{row: '0, col: '0, err: dgcp_pkg::ERR_RANGE};
        keep[0]    = 1'b1;
        failed_nxt = 1'b1;
      end else begin
        start_x_nxt = s1_r.x;
        start_y_nxt = s1_r.y;
        prev_x_nxt  = s1_r.x;
        prev_y_nxt  = s1_r.y;
        cur_row_nxt = r0;
        cur_col_nxt = c0;
        cand[0]     = '{row: r0, col: c0, err: dgcp_pkg::ERR_NONE};
        keep[0]     = !skipped(r0, c0, cfg.border, bnl, bnc);
        if (s1_r.last && s1_r.closed) begin
          cand[1] = '{row: '0, col: '0, err: dgcp_pkg::ERR_ADJ};
          keep[1] = 1'b1;
        end
        if (s1_r.last) begin
          failed_nxt = 1'b1;
        end
      end
    end else if (!failed_r) begin
      if (!in_grid) begin
        cand[0]    = '{row: '0, col: '0, err: dgcp_pkg::ERR_RANGE};
        keep[0]    = 1'b1;
        failed_nxt = 1'b1;
      end else if (!adj) begin
        cand[0]    = '{row: '0, col: '0, err: dgcp_pkg::ERR_ADJ};
        keep[0]    = 1'b1;
        failed_nxt = 1'b1;
      end else begin
        prev_x_nxt  = s1_r.x;
        prev_y_nxt  = s1_r.y;
        cur_row_nxt = r2;
        cur_col_nxt = c2;
        cand[0]     = '{row: r1, col: c1, err: dgcp_pkg::ERR_NONE};
        keep[0]     = !skipped(r1, c1, cfg.border, bnl, bnc);
        cand[1]     = '{row: r2, col: c2, err: dgcp_pkg::ERR_NONE};
        keep[1]     = !skipped(r2, c2, cfg.border, bnl, bnc);
        if (s1_r.last && s1_r.closed) begin
          if (cadj) begin
            cur_row_nxt = r3;
            cur_col_nxt = c3;
            cand[2]     = '{row: r3, col: c3, err: dgcp_pkg::ERR_NONE};
            keep[2]     = !skipped(r3, c3, cfg.border, bnl, bnc);
          end else begin
            cand[2] = '{row: '0, col: '0, err: dgcp_pkg::ERR_ADJ};
            keep[2] = 1'b1;
          end
        end
        if (s1_r.last) begin
          failed_nxt = 1'b1;
        end
      end
    end
  end

  // Pack the surviving entries to the low slots.
  always_comb begin
    set = '0;
    n   = '0;
    for (int i = 0; i < dgcp_pkg::SLOTS; i++) begin
      if (keep[i]) begin
        set.ent[n] = cand[i];
        n          = n + 2'd1;
      end
    end
    set.cnt = n;
  end

endmodule

`default_nettype wire

// ===== rtl/dgcp_drain.sv =====
// Result buffer and output register of the contour plotter: holds one entry set,
// sends one entry per transfer and forms the raster address. Depends on dgcp_pkg, dgcp_out_if.
`default_nettype none

module dgcp_drain (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire dgcp_pkg::cfg_t cfg,
  input  wire dgcp_pkg::set_t set,
  input  wire logic           set_valid,
  output logic                set_ready,
  dgcp_out_if.source          out_ch
);

  localparam int CW = dgcp_pkg::CUR_W;
  localparam int MW = 2 * CW;

  dgcp_pkg::set_t set_r;
  logic [1:0]     cnt_r, idx_r;
  logic           take, take_last;
  dgcp_pkg::pix_t ent;
  logic [CW-1:0]  width;
  logic [MW-1:0]  addr_full;

  logic                          ov_r;
  logic [dgcp_pkg::PIX_W-1:0]    row_r, col_r;
  logic [dgcp_pkg::ADDR_W-1:0]   addr_r;
  dgcp_pkg::err_t                err_r;
  logic                          last_r;

  assign ent       = set_r.ent[idx_r];
  assign take      = (cnt_r != 2'd0) && (!ov_r || out_ch.ready);
  assign take_last = take && (idx_r == cnt_r - 2'd1);
  assign set_ready = (cnt_r == 2'd0) || take_last;

  assign width     = cfg.border ? CW'({cfg.cols, 1'b0}) + CW'(1)
                                : CW'({cfg.cols, 1'b0}) - CW'(1);
  assign addr_full = MW'(ent.row) * MW'(width) + MW'(ent.col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (set_valid && set_ready) begin
      cnt_r <= set.cnt;
      idx_r <= '0;
    end else if (take_last) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
    if (set_valid && set_ready) begin
      set_r <= set;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (take) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
    if (take) begin
      row_r  <= ent.row[dgcp_pkg::PIX_W-1:0];
      col_r  <= ent.col[dgcp_pkg::PIX_W-1:0];
      addr_r <= addr_full[dgcp_pkg::ADDR_W-1:0];
      err_r  <= ent.err;
      last_r <= (idx_r == cnt_r - 2'd1);
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.pixel_row     = row_r;
  assign out_ch.pixel_col     = col_r;
  assign out_ch.pixel_address = addr_r;
  assign out_ch.error_code    = err_r;
  assign out_ch.last_result   = last_r;

  a_idx_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd0 |-> idx_r < cnt_r)
    else $error("drain index beyond entry count");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && err_r != dgcp_pkg::ERR_NONE |-> row_r == '0 && col_r == '0 && addr_r == '0)
    else $error("error result carries pixel data");

  a_load_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
    set_ready && cnt_r != 2'd0 |-> take_last)
    else $error("entry set replaced before drained");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3 || idx_r != 2'd3)
    else $error("drain index out of range");

endmodule

`default_nettype wire
